// File: sv/b64u_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the base64url decoder.
// No dependencies.
package b64u_pkg;

   localparam int ChWidth     = 8;
   localparam int SextetWidth = 6;
   localparam int AccWidth    = 12;
   localparam int CountWidth  = 3;
   localparam int ByteWidth   = 8;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_INVALID    = 2'd1,
      ST_DANGLING   = 2'd2,
      ST_NONZERO_PAD = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CC_SEXTET,
      CC_SPACE,
      CC_EQUALS,
      CC_INVALID
   } char_class_type;

   typedef struct packed {
      char_class_type           cls;
      logic [SextetWidth-1:0]   sextet;
   } char_info_type;

endpackage

// File: sv/b64u_req_if.sv
`timescale 1ns / 1ps
// Input channel: one character or end-of-string word per handshake.
// No dependencies.
interface b64u_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] ch;

   modport source (output valid, output op, output ch, input ready);
   modport sink   (input valid, input op, input ch, output ready);
endinterface

// File: sv/b64u_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: a decoded byte or the final status of a string.
// No dependencies.
interface b64u_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output kind, output data_byte, output status,
                   output last, input ready);
   modport sink   (input valid, input kind, input data_byte, input status,
                   input last, output ready);
endinterface

// File: sv/base64url_strict_decoder.sv
`timescale 1ns / 1ps
// Path: a word is held in the input register, then its result in the result register.
// Throughput: one word per cycle; the input register advances whenever the
// result register is free or the word yields no result.
// Reset: synchronous, clears accumulator, bit count, stop and error flags
// and both valid bits. Depends on b64u_pkg, b64u_req_if, b64u_rsp_if,
// b64u_char_class.
module base64url_strict_decoder (
   input  logic         clock,
   input  logic         reset,
   b64u_req_if.sink     req_if,
   b64u_rsp_if.source   rsp_if
);
   import b64u_pkg::*;

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_op_ff;
   logic [ChWidth-1:0]    s1_ch_ff;

   // decoder state
   logic [AccWidth-1:0]   acc_ff, acc_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic                  stopped_ff, stopped_in;
   logic                  bad_ff, bad_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  kind_ff, kind_in;
   logic [ByteWidth-1:0]  byte_ff, byte_in;
   status_type            status_ff, status_in;
   logic                  last_ff, last_in;

   char_info_type         info;
   logic                  produce;
   logic                  out_free;
   logic                  s1_fire;
   logic                  req_fire;
   logic [CountWidth:0]   sum;
   logic [AccWidth-1:0]   acc_shift;

   b64u_char_class u_class (
      .ch   (s1_ch_ff),
      .info (info)
   );

   assign sum       = {1'b0, cnt_ff} + (CountWidth+1)'(SextetWidth);
   assign acc_shift = {acc_ff[AccWidth-SextetWidth-1:0], info.sextet};

   always_comb begin
      produce    = 1'b0;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      stopped_in = stopped_ff;
      bad_in     = bad_ff;
      kind_in    = KIND_DATA;
      byte_in    = '0;
      status_in  = ST_OK;
      last_in    = 1'b0;
      if (s1_op_ff == OP_END) begin
         produce = 1'b1;
         kind_in = KIND_STATUS;
         last_in = 1'b1;
         if (bad_ff) begin
            status_in = ST_INVALID;
         end else if (cnt_ff >= CountWidth'(6)) begin
            status_in = ST_DANGLING;
         end else begin
            case (cnt_ff)
               3'd2:    status_in = (acc_ff[1:0] != '0) ? ST_NONZERO_PAD : ST_OK;
               3'd4:    status_in = (acc_ff[3:0] != '0) ? ST_NONZERO_PAD : ST_OK;
               default: status_in = ST_OK;
            endcase
         end
         acc_in     = '0;
         cnt_in     = '0;
         stopped_in = 1'b0;
         bad_in     = 1'b0;
      end else if (!stopped_ff && !bad_ff) begin
         unique case (info.cls)
            CC_EQUALS:  stopped_in = 1'b1;
            CC_INVALID: bad_in     = 1'b1;
            CC_SPACE:   ;
            CC_SEXTET: begin
               acc_in = acc_shift;
               if (sum >= (CountWidth+1)'(8)) begin
                  produce = 1'b1;
                  cnt_in  = CountWidth'(sum - (CountWidth+1)'(8));
                  case (cnt_in)
                     3'd2:    byte_in = acc_shift[9:2];
                     3'd4:    byte_in = acc_shift[11:4];
                     default: byte_in = acc_shift[7:0];
                  endcase
               end else begin
                  cnt_in = sum[CountWidth-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign s1_fire       = s1_valid_ff && (out_free || !produce);
   assign req_if.ready  = !s1_valid_ff || s1_fire;
   assign req_fire      = req_if.valid && req_if.ready;
   assign s1_valid_in   = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in  = (s1_fire && produce) ? 1'b1
                        : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         stopped_ff   <= 1'b0;
         bad_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            acc_ff     <= acc_in;
            cnt_ff     <= cnt_in;
            stopped_ff <= stopped_in;
            bad_ff     <= bad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff <= req_if.op;
         s1_ch_ff <= req_if.ch;
      end
      if (s1_fire && produce) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.kind      = kind_ff;
   assign rsp_if.data_byte = byte_ff;
   assign rsp_if.status    = status_ff;
   assign rsp_if.last      = last_ff;

endmodule

// File: sv/b64u_char_class.sv
`timescale 1ns / 1ps
// Character classifier: maps a code to its class and 6-bit alphabet value.
// Depends on b64u_pkg.
module b64u_char_class (
   input  logic [b64u_pkg::ChWidth-1:0] ch,
   output b64u_pkg::char_info_type      info
);
   import b64u_pkg::*;

   logic [ChWidth-1:0] val;

   always_comb begin
      val      = '0;
      info.cls = CC_INVALID;
      unique case (ch) inside
         [8'h41:8'h5A]: begin   // A-Z
            info.cls = CC_SEXTET;
            val      = ch - 8'd65;
         end
         [8'h61:8'h7A]: begin   // a-z
            info.cls = CC_SEXTET;
            val      = ch - 8'd71;
         end
         [8'h30:8'h39]: begin   // 0-9
            info.cls = CC_SEXTET;
            val      = ch + 8'd4;
         end
         8'h2D: begin           // '-'
            info.cls = CC_SEXTET;
            val      = 8'd62;
         end
         8'h5F: begin           // '_'
            info.cls = CC_SEXTET;
            val      = 8'd63;
         end
         8'h3D: begin
            info.cls = CC_EQUALS;
         end
         8'h20, 8'h09, 8'h0D, 8'h0A: begin
            info.cls = CC_SPACE;
         end
         default: begin
            info.cls = CC_INVALID;
         end
      endcase
      info.sextet = val[SextetWidth-1:0];
   end

endmodule

// File: sim/base64url_strict_decoder_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the base64url decoder: watches both channels, predicts each
// result word from accepted input words and compares in order. Needs b64u_pkg.
module base64url_strict_decoder_checker
   import b64u_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_op,
   input  logic [ChWidth-1:0]   req_ch,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_kind,
   input  logic [ByteWidth-1:0] rsp_data_byte,
   input  logic [1:0]           rsp_status,
   input  logic                 rsp_last,
   output int                   mismatch_count,
   output int                   pending_count
);

   localparam int MaxReports = 10;
   localparam int NotSextet  = 64;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_EQUALS = "=";

   typedef struct packed {
      logic                 kind;
      logic [ByteWidth-1:0] data_byte;
      status_type           status;
      logic                 last;
   } decode_result_type;

   decode_result_type   expected_results[$];
   logic [AccWidth-1:0] acc_bits;
   logic [3:0]          bits_held;
   logic                stop_seen;
   logic                error_seen;

   function automatic int sextet_of_char(input logic [7:0] ch);
      if (ch >= "A" && ch <= "Z") return ch - "A";
      if (ch >= "a" && ch <= "z") return ch - "a" + 26;
      if (ch >= "0" && ch <= "9") return ch - "0" + 52;
      if (ch == "-") return 62;
      if (ch == "_") return 63;
      return NotSextet;
   endfunction

   function automatic void clear_string_state();
      acc_bits   = '0;
      bits_held  = '0;
      stop_seen  = 1'b0;
      error_seen = 1'b0;
   endfunction

   function automatic void predict_word(input logic op, input logic [7:0] ch);
      decode_result_type   res;
      int                  sextet;
      logic [AccWidth-1:0] low_mask;
      if (op == OP_END) begin
         res.kind      = KIND_STATUS;
         res.data_byte = '0;
         res.last      = 1'b1;
         low_mask      = (12'd1 << bits_held) - 12'd1;
         if (error_seen) begin
            res.status = ST_INVALID;
         end else if (bits_held >= 4'd6) begin
            res.status = ST_DANGLING;
         end else if ((acc_bits & low_mask) != '0) begin
            res.status = ST_NONZERO_PAD;
         end else begin
            res.status = ST_OK;
         end
         expected_results = {expected_results, res};
         clear_string_state();
         return;
      end
      if (stop_seen || error_seen) return;
      if (ch == CH_EQUALS) begin
         stop_seen = 1'b1;
         return;
      end
      if (ch == CH_TAB || ch == CH_LF || ch == CH_CR || ch == CH_SPACE) return;
      sextet = sextet_of_char(ch);
      if (sextet == NotSextet) begin
         error_seen = 1'b1;
         return;
      end
      acc_bits  = {acc_bits[AccWidth-SextetWidth-1:0], sextet[SextetWidth-1:0]};
      bits_held = bits_held + 4'd6;
      if (bits_held >= 4'd8) begin
         bits_held     = bits_held - 4'd8;
         res.kind      = KIND_DATA;
         res.data_byte = ByteWidth'(acc_bits >> bits_held);
         res.status    = ST_OK;
         res.last      = 1'b0;
         expected_results = {expected_results, res};
      end
   endfunction

   always @(posedge clock) begin
      decode_result_type want;
      decode_result_type got;
      if (reset) begin
         clear_string_state();
         expected_results.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.kind      = rsp_kind;
            got.data_byte = rsp_data_byte;
            got.status    = status_type'(rsp_status);
            got.last      = rsp_last;
            if (expected_results.size() == 0) begin
               if (mismatch_count < MaxReports)
                  $display("unexpected result word: kind %0d byte %02h status %0d last %0d",
                           got.kind, got.data_byte, got.status, got.last);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  if (mismatch_count < MaxReports)
                     $display({"mismatch at %0t: expected kind %0d byte %02h status %0d",
                               " last %0d, got kind %0d byte %02h status %0d last %0d"},
                              $realtime, want.kind, want.data_byte, want.status,
                              want.last, got.kind, got.data_byte, got.status,
                              got.last);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) predict_word(req_op, req_ch);
      end
      pending_count <= expected_results.size();
   end

endmodule

// File: sim/base64url_strict_decoder_tb.sv
`timescale 1ns / 1ps
// Top of the decoder testbench: clock, reset, character stimulus, receiver
// stalls, watchdog and verdict. Needs b64u_pkg, both channel interfaces,
// base64url_strict_decoder and base64url_strict_decoder_checker.
module base64url_strict_decoder_tb;
   import b64u_pkg::*;

   localparam int ClockPeriod   = 20;
   localparam int ResetCycles   = 10;
   localparam int HoldCycles    = 300;
   localparam int WatchdogLimit = 4000;
   localparam int DrainCycles   = 8;
   localparam int PhaseWords    = 380;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int idle_pct      = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int words_sent    = 0;
   int quiet_cycles  = 0;
   int mismatch_count;
   int pending_count;

   b64u_req_if req_if ();
   b64u_rsp_if rsp_if ();

   base64url_strict_decoder u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   base64url_strict_decoder_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_op         (req_if.op),
      .req_ch         (req_if.ch),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_kind       (rsp_if.kind),
      .rsp_data_byte  (rsp_if.data_byte),
      .rsp_status     (rsp_if.status),
      .rsp_last       (rsp_if.last),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off whenever one is requested
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served++;
            rsp_if.ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_word(input logic op, input logic [7:0] ch);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op    <= op;
      req_if.ch    <= ch;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_word(OP_CHAR, text[i]);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] alphabet_char(input int unsigned sextet);
      if (sextet < 26) return 8'("A" + sextet);
      if (sextet < 52) return 8'("a" + sextet - 26);
      if (sextet < 62) return 8'("0" + sextet - 52);
      if (sextet == 62) return "-";
      return "_";
   endfunction

   function automatic logic [7:0] space_char();
      case ($urandom_range(3))
         0: begin
            return 8'h20;
         end
         1: begin
            return 8'h09;
         end
         2: begin
            return 8'h0D;
         end
         default: begin
            return 8'h0A;
         end
      endcase
   endfunction

   function automatic logic [7:0] bad_char();
      case ($urandom_range(5))
         0: begin
            return "+";
         end
         1: begin
            return "/";
         end
         2: begin
            return 8'h00;
         end
         3: begin
            return 8'h7F;
         end
         4: begin
            return "*";
         end
         default: begin
            return 8'($urandom_range(128, 255));
         end
      endcase
   endfunction

   // mostly clean strings; some cut by '=', some broken, some pure noise
   task automatic send_random_string();
      int          shape;
      int          len;
      int          mark;
      logic [7:0]  ch;
      shape = $urandom_range(99);
      len   = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
      mark  = $urandom_range(len);
      for (int i = 0; i < len; i++) begin
         if (shape >= 90) begin
            ch = 8'($urandom_range(255));
         end else if (shape >= 70 && i == mark) begin
            ch = (shape >= 80) ? "=" : bad_char();
         end else if (shape >= 70 && i > mark && $urandom_range(1) == 0) begin
            ch = 8'($urandom_range(255));
         end else if ($urandom_range(99) < 8) begin
            ch = space_char();
         end else begin
            ch = alphabet_char($urandom_range(63));
         end
         send_word(OP_CHAR, ch);
      end
      send_word(OP_END, 8'($urandom_range(255)));
   endtask

   initial begin
      int phase_end;
      req_if.valid = 1'b0;
      req_if.op    = OP_CHAR;
      req_if.ch    = '0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(OP_END, 8'h00);
      send_text("TWFu");
      send_word(OP_END, 8'hFF);
      send_text("QR");
      send_word(OP_END, 8'h00);
      send_text("Q");
      send_word(OP_END, 8'h00);
      send_text("-_\t\r\n z9");
      send_word(OP_END, 8'h00);
      send_text("Q=+");
      send_word(OP_END, 8'h00);
      send_text("Q");
      send_word(OP_CHAR, 8'hFF);
      send_text("Q");
      send_word(OP_END, 8'h00);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 86;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 86;
            end
            default: begin
               idle_pct  = 9;
               stall_pct = 9;
            end
         endcase
         if (phase == 0) begin
            // long receiver hold-off while a long clean string keeps coming
            hold_requests++;
            for (int i = 0; i < 40; i++) send_word(OP_CHAR, alphabet_char($urandom_range(63)));
            send_word(OP_END, 8'h00);
         end
         phase_end = words_sent + PhaseWords;
         while (words_sent < phase_end) send_random_string();
         wait_drained();
      end

      repeat (DrainCycles) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
